// ===== src/assert_macros.svh =====
// assertion macros shared by the chunk demux modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must never hold
`define ACD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// same-cycle implication
`define ACD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ACD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/acd_pkg.sv =====
// types and constants for the avi chunk demux
// no dependencies
`default_nettype none

package acd_pkg;

  // four-character codes, little-endian
  localparam logic [31:0] FCC_LIST     = 32'h5453_494C;
  localparam logic [31:0] FCC_REC      = 32'h2063_6572;
  localparam logic [31:0] FCC_MOVI     = 32'h6976_6F6D;
  localparam logic [15:0] KIND_DB      = 16'h6264;
  localparam logic [15:0] KIND_DC      = 16'h6364;
  localparam logic [15:0] KIND_WB      = 16'h6277;
  localparam logic [31:0] RIFF_HDR_LEN = 32'd12;

  // configuration register indexes
  localparam int CFG_IW = 2;
  localparam logic [CFG_IW-1:0] CFG_TARGET_TYPE = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_VIDEO_EN    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_AUDIO_EN    = 2'd2;

  // result queue between parser and output stage
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_id;
    logic       chunk_last;
    logic       finished;
  } res_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  typedef enum logic [13:0] {
    PH_HDR    = 14'b00_0000_0000_0001,
    PH_S_ID   = 14'b00_0000_0000_0010,
    PH_S_LSZ  = 14'b00_0000_0000_0100,
    PH_S_CSZ  = 14'b00_0000_0000_1000,
    PH_S_TYPE = 14'b00_0000_0001_0000,
    PH_S_SKIP = 14'b00_0000_0010_0000,
    PH_S_PAD  = 14'b00_0000_0100_0000,
    PH_M_ID   = 14'b00_0000_1000_0000,
    PH_M_LSZ  = 14'b00_0001_0000_0000,
    PH_M_LTYP = 14'b00_0010_0000_0000,
    PH_M_SIZE = 14'b00_0100_0000_0000,
    PH_M_DATA = 14'b00_1000_0000_0000,
    PH_M_PAD  = 14'b01_0000_0000_0000,
    PH_DONE   = 14'b10_0000_0000_0000
  } phase_t;

endpackage

`default_nettype wire

// ===== src/acd_front.sv =====
// byte parser: walks riff chunks, finds the target list, classifies items
// depends on acd_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module acd_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [acd_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [31:0]               cfg_data,
  input  wire logic                      in_valid,
  input  wire logic [7:0]                in_byte,
  output      logic                      in_stall,
  input  wire acd_pkg::q_stat_t          q_stat,
  output      logic                      push,
  output      acd_pkg::res_t             push_res
);
  import acd_pkg::*;

  logic [31:0] target_r;
  logic        video_en_r;
  logic        audio_en_r;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  fbi_r, fbi_nxt;
  logic [31:0] word_r, word_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic        vid_r, vid_nxt;
  logic        pad_r, pad_nxt;

  logic        accept;
  logic [31:0] word_in;
  logic        word_full;
  logic [31:0] rem_dec;
  logic [31:0] skip_len;

  assign in_stall  = q_stat.full;
  assign accept    = in_valid & ~q_stat.full;
  assign word_in   = {in_byte, word_r[31:8]};
  assign word_full = (fbi_r == 2'd3);
  assign rem_dec   = rem_r - 32'd1;
  assign skip_len  = (rem_r >= 32'd4) ? (rem_r - 32'd4) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r   <= FCC_MOVI;
      video_en_r <= 1'b1;
      audio_en_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TARGET_TYPE: target_r   <= cfg_data;
        CFG_VIDEO_EN:    video_en_r <= cfg_data[0];
        CFG_AUDIO_EN:    audio_en_r <= cfg_data[0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    fbi_nxt   = fbi_r;
    word_nxt  = word_r;
    rem_nxt   = rem_r;
    vid_nxt   = vid_r;
    pad_nxt   = pad_r;
    push      = 1'b0;
    push_res  = '0;
    if (accept) begin
      case (phase_r)
        PH_HDR: begin
          if (rem_r <= 32'd1) phase_nxt = PH_S_ID;
          if (rem_r != 32'd0) rem_nxt = rem_dec;
        end
        PH_S_ID: begin
          fbi_nxt  = fbi_r + 2'd1;
          word_nxt = word_in;
          if (word_full) phase_nxt = (word_in == FCC_LIST) ? PH_S_LSZ : PH_S_CSZ;
        end
        PH_S_LSZ: begin
          fbi_nxt  = fbi_r + 2'd1;
          word_nxt = word_in;
          if (word_full) begin
            rem_nxt   = word_in;
            phase_nxt = PH_S_TYPE;
          end
        end
        PH_S_CSZ: begin
          fbi_nxt  = fbi_r + 2'd1;
          word_nxt = word_in;
          if (word_full) begin
            rem_nxt = word_in;
            pad_nxt = word_in[0];
            if (word_in != 32'd0) phase_nxt = PH_S_SKIP;
            else                  phase_nxt = PH_S_ID;
          end
        end
        PH_S_TYPE: begin
          fbi_nxt  = fbi_r + 2'd1;
          word_nxt = word_in;
          if (word_full) begin
            if (word_in == target_r) begin
              phase_nxt = PH_M_ID;
            end else begin
              rem_nxt = skip_len;
              pad_nxt = rem_r[0];
              if (skip_len != 32'd0) phase_nxt = PH_S_SKIP;
              else if (rem_r[0])     phase_nxt = PH_S_PAD;
              else                   phase_nxt = PH_S_ID;
            end
          end
        end
        PH_S_SKIP: begin
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) phase_nxt = pad_r ? PH_S_PAD : PH_S_ID;
        end
        PH_S_PAD: begin
          pad_nxt   = 1'b0;
          phase_nxt = PH_S_ID;
        end
        PH_M_ID: begin
          fbi_nxt  = fbi_r + 2'd1;
          word_nxt = word_in;
          if (word_full) begin
            if (word_in[31:16] == KIND_DB || word_in[31:16] == KIND_DC) begin
              vid_nxt   = 1'b1;
              phase_nxt = PH_M_SIZE;
            end else if (word_in[31:16] == KIND_WB) begin
              vid_nxt   = 1'b0;
              phase_nxt = PH_M_SIZE;
            end else if (word_in == FCC_LIST) begin
              phase_nxt = PH_M_LSZ;
            end else begin
              phase_nxt         = PH_DONE;
              push              = 1'b1;
              push_res.finished = 1'b1;
            end
          end
        end
        PH_M_LSZ: begin
          fbi_nxt  = fbi_r + 2'd1;
          word_nxt = word_in;
          if (word_full) phase_nxt = PH_M_LTYP;
        end
        PH_M_LTYP: begin
          fbi_nxt  = fbi_r + 2'd1;
          word_nxt = word_in;
          if (word_full) begin
            if (word_in == FCC_REC) begin
              phase_nxt = PH_M_ID;
            end else begin
              phase_nxt         = PH_DONE;
              push              = 1'b1;
              push_res.finished = 1'b1;
            end
          end
        end
        PH_M_SIZE: begin
          fbi_nxt  = fbi_r + 2'd1;
          word_nxt = word_in;
          if (word_full) begin
            rem_nxt = word_in;
            pad_nxt = word_in[0];
            if (word_in == 32'd0) phase_nxt = PH_M_ID;
            else                  phase_nxt = PH_M_DATA;
          end
          // video size bytes go out too
          if (vid_r && video_en_r) begin
            push                = 1'b1;
            push_res.data_byte  = in_byte;
            push_res.chunk_last = word_full && (word_in == 32'd0);
          end
        end
        PH_M_DATA: begin
          rem_nxt = rem_dec;
          if (rem_dec == 32'd0) phase_nxt = pad_r ? PH_M_PAD : PH_M_ID;
          if (vid_r ? video_en_r : audio_en_r) begin
            push                = 1'b1;
            push_res.data_byte  = in_byte;
            push_res.stream_id  = ~vid_r;
            push_res.chunk_last = (rem_dec == 32'd0);
          end
        end
        PH_M_PAD: begin
          pad_nxt   = 1'b0;
          phase_nxt = PH_M_ID;
        end
        default: ;  // stopped: bytes are swallowed
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR;
      fbi_r   <= 2'd0;
      word_r  <= 32'd0;
      rem_r   <= RIFF_HDR_LEN;
      vid_r   <= 1'b0;
      pad_r   <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      fbi_r   <= fbi_nxt;
      word_r  <= word_nxt;
      rem_r   <= rem_nxt;
      vid_r   <= vid_nxt;
      pad_r   <= pad_nxt;
    end
  end

  `ACD_ASSERT_IMPL(a_done_silent, phase_r == PH_DONE, !push, "push after parsing stopped")
  `ACD_ASSERT_NEXT(a_done_sticky, phase_r == PH_DONE, phase_r == PH_DONE, "left stopped phase")

endmodule

`default_nettype wire

// ===== src/acd_queue.sv =====
// short result queue between parser and output stage
// depends on acd_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module acd_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire acd_pkg::res_t push_res,
  input  wire logic          pop,
  output      acd_pkg::res_t head_res,
  output      acd_pkg::q_stat_t q_stat
);
  import acd_pkg::*;

  res_t            mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;

  assign q_stat.empty = (count_r == Q_CW'(0));
  assign q_stat.full  = (count_r == Q_CW'(Q_DEPTH));
  assign head_res     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push)
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_AW'(1);
    if (pop)
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_AW'(1);
    if (push && !pop)      count_nxt = count_r + Q_CW'(1);
    else if (!push && pop) count_nxt = count_r - Q_CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `ACD_ASSERT_NEVER(a_q_overflow, push && q_stat.full, "push into full queue")
  `ACD_ASSERT_NEVER(a_q_underflow, pop && q_stat.empty, "pop from empty queue")

endmodule

`default_nettype wire

// ===== src/acd_back.sv =====
// output stage: registers the queue head and presents it to the sink
// depends on acd_pkg, assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module acd_back (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire acd_pkg::q_stat_t q_stat,
  input  wire acd_pkg::res_t    head_res,
  output      logic             pop,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      logic [7:0]       out_data_byte,
  output      logic             out_stream_id,
  output      logic             out_chunk_last,
  output      logic             out_finished
);
  import acd_pkg::*;

  logic out_valid_r, out_valid_nxt;
  res_t res_r;

  // refill whenever the register is empty or being taken
  assign pop = !q_stat.empty && (!out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop)             out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (pop) res_r <= head_res;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= out_valid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_data_byte  = res_r.data_byte;
  assign out_stream_id  = res_r.stream_id;
  assign out_chunk_last = res_r.chunk_last;
  assign out_finished   = res_r.finished;

  `ACD_ASSERT_NEXT(a_back_fill, !q_stat.empty && !out_valid_r, out_valid_r, "head not loaded")

endmodule

`default_nettype wire

// ===== src/avi_movi_chunk_demux.sv =====
// top level of the avi chunk demux: parser, result queue, output stage
// depends on acd_pkg, acd_front, acd_queue, acd_back
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_stall   in_byte
//  out      source     out_valid / out_stall out_data_byte, out_stream_id,
//                                            out_chunk_last, out_finished
//  cfg      sink       cfg_we                cfg_index, cfg_data
//
// one byte is accepted every cycle while the 4-entry result queue has room
// out_valid rises once a result moves from the queue to the output register
// in_stall rises only when the queue is full, i.e. the sink has stalled
// synchronous reset restores the config defaults and restarts at the riff header
`default_nettype none

module avi_movi_chunk_demux (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [acd_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [31:0]                cfg_data,
  input  wire logic                       in_valid,
  output      logic                       in_stall,
  input  wire logic [7:0]                 in_byte,
  output      logic                       out_valid,
  input  wire logic                       out_stall,
  output      logic [7:0]                 out_data_byte,
  output      logic                       out_stream_id,
  output      logic                       out_chunk_last,
  output      logic                       out_finished
);
  import acd_pkg::*;

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  res_t    push_res;
  res_t    head_res;

  acd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_byte  (in_byte),
    .in_stall (in_stall),
    .q_stat   (q_stat),
    .push     (push),
    .push_res (push_res)
  );

  acd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_res(push_res),
    .pop     (pop),
    .head_res(head_res),
    .q_stat  (q_stat)
  );

  acd_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .head_res      (head_res),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data_byte (out_data_byte),
    .out_stream_id (out_stream_id),
    .out_chunk_last(out_chunk_last),
    .out_finished  (out_finished)
  );

endmodule

`default_nettype wire
